// File: rtl/core/fccm_pkg.sv
// Shared types, codes and defaults for the FAT chain manager.
package fccm_pkg;

	localparam int BLOCKS_DEF = 1024;
	localparam int BLOCK_W    = 10;

	// command codes
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BROKEN = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [BLOCK_W-1:0] block;
		logic               has_tail;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [BLOCK_W-1:0] result_block;
		logic               at_end;
	} rsp_t;

endpackage

// File: rtl/core/fat_cluster_chain_manager.sv
// Top level of the FAT chain manager: command sequencer around the link table.
//
// Keeps one link entry per disk block (free, end of chain, or next block) in a
// single synchronous RAM and runs one command at a time. After reset a
// clearing pass writes every entry (block 0 as end, all others free), during
// which req_stall stays high. Free walks the chain, each step reading the next
// link while writing the current one free. Append scans the table one entry per
// cycle starting at a low-water mark below which every entry is known to be in
// use; the mark moves past each allocated block and back down when a chain is
// freed. A new command is taken only after the previous one finished; a
// finished result sits in the output register until it is transferred.
module fat_cluster_chain_manager #(
	parameter int BLOCKS = fccm_pkg::BLOCKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fccm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fccm_pkg::rsp_t rsp
);

	localparam int AW = $clog2(BLOCKS);      // table address
	localparam int HW = $clog2(BLOCKS+1);    // low-water mark, may equal BLOCKS
	localparam int LW = $clog2(BLOCKS+2);    // link entry
	localparam int BW = fccm_pkg::BLOCK_W;

	localparam logic [LW-1:0] LINK_END  = LW'(BLOCKS);
	localparam logic [LW-1:0] LINK_FREE = LW'(BLOCKS+1);
	localparam logic [AW-1:0] LAST      = AW'(BLOCKS-1);
	localparam logic [HW-1:0] MARK_FULL = HW'(BLOCKS);

	// sequencer states
	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_APP_END = 3'd3;
	localparam logic [2:0] S_FREE    = 3'd4;
	localparam logic [2:0] S_LOOK    = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic [HW-1:0]  hint_q;      // every entry below this is in use
	logic [HW-1:0]  scan_q;      // next address to issue during the scan
	logic [AW-1:0]  cur_q;       // chain entry being freed
	logic [AW-1:0]  steps_q;
	logic [AW-1:0]  tail_q;
	logic           has_tail_q;
	logic [AW-1:0]  fresh_q;
	logic [AW-1:0]  rd_addr_s1;  // address whose data shows on rd_link
	fccm_pkg::rsp_t res_q;
	fccm_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [LW-1:0]  mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [LW-1:0]  rd_link;

	logic [31:0]    req_blk32;
	logic           req_oob;
	logic [AW-1:0]  req_addr;
	logic [31:0]    link32;
	logic [AW-1:0]  link_addr;
	logic [31:0]    rd_addr32;
	logic           out_free;
	logic           rsp_load;    // finished result moves into the output register

	assign req_blk32 = 32'(req.block);
	assign req_oob   = req_blk32 >= 32'(BLOCKS);
	assign req_addr  = req_blk32[AW-1:0];
	assign link32    = 32'(rd_link);
	assign link_addr = link32[AW-1:0];
	assign rd_addr32 = 32'(rd_addr_s1);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = (state_q == S_FIN) && out_free;

	fccm_link_store #(
		.BLOCKS(BLOCKS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (rd_link)
	);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = LINK_FREE;
		mem_raddr = scan_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == '0) ? LINK_END : LINK_FREE;
			end
			S_IDLE: begin
				mem_raddr = (req.mode == fccm_pkg::MODE_APPEND) ? hint_q[AW-1:0] : req_addr;
			end
			S_SCAN: begin
				// link the tail to the block just found; the end mark follows next cycle
				if (rd_link == LINK_FREE && has_tail_q) begin
					mem_we    = 1'b1;
					mem_waddr = tail_q;
					mem_wdata = LW'(rd_addr_s1);
				end
			end
			S_APP_END: begin
				mem_we    = 1'b1;
				mem_waddr = fresh_q;
				mem_wdata = LINK_END;
			end
			S_FREE: begin
				// free this entry while fetching the next one
				mem_we    = rd_link != LINK_FREE;
				mem_raddr = link_addr;
			end
			S_LOOK, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hint_q      <= HW'(1);
			scan_q      <= '0;
			cur_q       <= '0;
			steps_q     <= '0;
			tail_q      <= '0;
			has_tail_q  <= 1'b0;
			fresh_q     <= '0;
			rd_addr_s1  <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_addr_s1 <= mem_raddr;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						res_q   <= '0;
						state_q <= S_FIN;
						case (req.mode)
							fccm_pkg::MODE_APPEND: begin
								if (req.has_tail && req_oob) begin
									res_q.status <= fccm_pkg::ST_BROKEN;
								end else if (hint_q == MARK_FULL) begin
									res_q.status <= fccm_pkg::ST_FULL;
								end else begin
									tail_q     <= req_addr;
									has_tail_q <= req.has_tail;
									scan_q     <= hint_q + HW'(1);
									state_q    <= S_SCAN;
								end
							end
							fccm_pkg::MODE_FREE: begin
								if (req_oob) begin
									res_q.status <= fccm_pkg::ST_BROKEN;
								end else begin
									cur_q   <= req_addr;
									steps_q <= '0;
									state_q <= S_FREE;
								end
							end
							fccm_pkg::MODE_LOOKUP: begin
								if (req_oob) begin
									res_q.status <= fccm_pkg::ST_BROKEN;
								end else begin
									state_q <= S_LOOK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_link == LINK_FREE) begin
						fresh_q             <= rd_addr_s1;
						hint_q              <= HW'(rd_addr_s1) + HW'(1);
						res_q.status        <= fccm_pkg::ST_OK;
						res_q.result_block  <= rd_addr32[BW-1:0];
						res_q.at_end        <= 1'b0;
						state_q             <= S_APP_END;
					end else if (rd_addr_s1 == LAST) begin
						hint_q       <= MARK_FULL;
						res_q.status <= fccm_pkg::ST_FULL;
						state_q      <= S_FIN;
					end else begin
						scan_q <= scan_q + HW'(1);
					end
				end
				S_APP_END: begin
					state_q <= S_FIN;
				end
				S_FREE: begin
					if (rd_link == LINK_FREE) begin
						res_q.status <= fccm_pkg::ST_BROKEN;
						state_q      <= S_FIN;
					end else begin
						if (HW'(cur_q) < hint_q) begin
							hint_q <= HW'(cur_q);
						end
						if (rd_link == LINK_END) begin
							res_q.status <= fccm_pkg::ST_OK;
							state_q      <= S_FIN;
						end else if (steps_q == LAST) begin
							// walked BLOCKS entries without reaching an end
							res_q.status <= fccm_pkg::ST_BROKEN;
							state_q      <= S_FIN;
						end else begin
							steps_q <= steps_q + AW'(1);
							cur_q   <= link_addr;
						end
					end
				end
				S_LOOK: begin
					if (rd_link == LINK_FREE) begin
						res_q.status <= fccm_pkg::ST_BROKEN;
					end else if (rd_link == LINK_END) begin
						res_q.at_end <= 1'b1;
					end else begin
						res_q.result_block <= link32[BW-1:0];
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_load) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/fccm_link_store.sv
// Link table memory: one write port, one registered read port, same-cycle forwarding.
module fccm_link_store #(
	parameter int BLOCKS = fccm_pkg::BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [$clog2(BLOCKS)-1:0]     waddr,
	input  logic [$clog2(BLOCKS+2)-1:0]   wdata,
	input  logic [$clog2(BLOCKS)-1:0]     raddr,
	output logic [$clog2(BLOCKS+2)-1:0]   rdata
);

	localparam int LW = $clog2(BLOCKS+2);

	logic [LW-1:0] mem [BLOCKS];
	logic [LW-1:0] rd_s1;
	logic [LW-1:0] fwd_data_s1;
	logic          fwd_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1       <= mem[raddr];
		fwd_data_s1 <= wdata;
	end

	// a read that meets a write to the same entry returns the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else begin
			fwd_s1 <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_s1 ? fwd_data_s1 : rd_s1;

endmodule

// File: rtl/core/fccm_checker.sv
// Port-level checks for the FAT chain manager, bound to the top level.
module fccm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input fccm_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fccm_pkg::rsp_t rsp
);

	// a result held back by the receiver stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one command at a time: a transfer closes the input side next cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input open right after a transfer");

	// any error result carries no block and no end flag
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == fccm_pkg::ST_FULL || rsp.status == fccm_pkg::ST_BROKEN)
		|-> rsp.result_block == '0 && !rsp.at_end)
		else $error("error result with payload");

	// end flag only on a good lookup with no next block
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.at_end |-> rsp.status == fccm_pkg::ST_OK && rsp.result_block == '0)
		else $error("end flag with payload");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == fccm_pkg::ST_OK || rsp.status == fccm_pkg::ST_FULL ||
			rsp.status == fccm_pkg::ST_BROKEN)
		else $error("undefined status");

endmodule

bind fat_cluster_chain_manager fccm_checker u_fccm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
